/* rtl/core/mexp_pkg.sv */
// Shared constants for the modular exponentiation block.
// No dependencies; the top level takes its default operand width from here.
package mexp_pkg;

	// Default width of the modulus, the base, the exponent and the result.
	localparam int OPERAND_WIDTH_DEF = 32;

endpackage

/* rtl/core/modular_exponentiation.sv */
// Modular exponentiation top level: left-to-right square and multiply over a
// shared bit-serial modular multiplier. Depends on mexp_pkg.
//
// Usage: the modulus is written through cfg_write_en / cfg_write_data while the
// block is idle. It resets to all ones. Each transfer on the input channel
// (in_valid high, in_stall low) carries a base and an exponent. Exactly one
// transfer on the output channel follows, carrying base^exponent mod modulus.
// The base is first reduced by the modulus. Then every exponent bit, from the
// top bit down, costs one modular squaring, plus one modular multiply when the
// bit is set; both run on the shared double-and-add unit. A zero modulus skips
// the multiplier and goes straight to the write state, which returns 0.
// in_stall is high from the input transfer until the result has moved into the
// output register. The next item can be taken while that result still waits.
// A stalled result holds in the output register. A finished computation then
// waits in its last state and the block takes no new item. Reset clears the
// sequencer and the output valid flag, and sets the modulus to all ones.
module modular_exponentiation #(
	parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [OPERAND_WIDTH-1:0] cfg_write_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OPERAND_WIDTH-1:0] base_value,
	input  logic [OPERAND_WIDTH-1:0] exponent,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [OPERAND_WIDTH-1:0] power_result
);

	localparam int CNT_W = $clog2(OPERAND_WIDTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OPERAND_WIDTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_WRITE
	} state_t;

	state_t                   state_q;
	logic [OPERAND_WIDTH-1:0] modulus_q;
	logic [OPERAND_WIDTH-1:0] acc_q;        // running sum of the multiplier
	logic [OPERAND_WIDTH-1:0] mul_a_q;      // multiplicand, below the modulus while the multiplier runs
	logic [OPERAND_WIDTH-1:0] mul_b_q;      // multiplier, consumed from its top bit
	logic [OPERAND_WIDTH-1:0] base_q;       // base after reduction
	logic [OPERAND_WIDTH-1:0] run_q;        // final value handed to the output
	logic [OPERAND_WIDTH-1:0] exp_q;        // exponent, shifted left bit by bit
	logic [CNT_W-1:0]         step_cnt_q;
	logic [CNT_W-1:0]         exp_cnt_q;
	logic                     out_valid_q;
	logic [OPERAND_WIDTH-1:0] power_result_q;

	logic [OPERAND_WIDTH:0]   dbl;
	logic [OPERAND_WIDTH-1:0] dbl_red;
	logic [OPERAND_WIDTH:0]   sum;
	logic [OPERAND_WIDTH-1:0] add_red;
	logic [OPERAND_WIDTH-1:0] step_val;
	logic [OPERAND_WIDTH-1:0] one_mod;
	logic                     step_last;
	logic                     exp_last;
	logic                     out_free;

	// One step of the shared modular multiplier: the sum is doubled and reduced.
	// When the current multiplier bit is set, the multiplicand is added and the
	// sum is reduced again. Both operands stay below the modulus, so one
	// conditional subtract is enough each time.
	always_comb begin
		dbl = {acc_q, 1'b0};
		if (dbl >= {1'b0, modulus_q}) begin
			dbl_red = OPERAND_WIDTH'(dbl - {1'b0, modulus_q});
		end else begin
			dbl_red = dbl[OPERAND_WIDTH-1:0];
		end
		sum = {1'b0, dbl_red} + {1'b0, mul_a_q};
		if (sum >= {1'b0, modulus_q}) begin
			add_red = OPERAND_WIDTH'(sum - {1'b0, modulus_q});
		end else begin
			add_red = sum[OPERAND_WIDTH-1:0];
		end
		step_val = mul_b_q[OPERAND_WIDTH-1] ? add_red : dbl_red;
	end

	// 1 mod modulus. It is 0 only when the modulus is one.
	assign one_mod   = {{(OPERAND_WIDTH-1){1'b0}}, (modulus_q != OPERAND_WIDTH'(1))};
	assign step_last = (step_cnt_q == LAST_STEP);
	assign exp_last  = (exp_cnt_q == LAST_STEP);
	assign out_free  = !out_valid_q || !out_stall;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = power_result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			modulus_q      <= '1;
			acc_q          <= '0;
			mul_a_q        <= '0;
			mul_b_q        <= '0;
			base_q         <= '0;
			run_q          <= '0;
			exp_q          <= '0;
			step_cnt_q     <= '0;
			exp_cnt_q      <= '0;
			out_valid_q    <= 1'b0;
			power_result_q <= '0;
		end else begin
			if (cfg_write_en) begin
				modulus_q <= cfg_write_data;
			end
			// A new result takes the output register as soon as it is free.
			if (state_q == ST_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						exp_q      <= exponent;
						exp_cnt_q  <= '0;
						step_cnt_q <= '0;
						acc_q      <= '0;
						if (modulus_q == '0) begin
							// A zero modulus is outside the range, and the answer is 0.
							run_q   <= '0;
							state_q <= ST_WRITE;
						end else begin
							// The base is reduced by multiplying (1 mod N) by it.
							mul_a_q <= one_mod;
							mul_b_q <= base_value;
							state_q <= ST_REDUCE;
						end
					end
				end

				ST_REDUCE: begin
					if (step_last) begin
						// The running value starts at 1 mod N, and it is squared first.
						base_q     <= step_val;
						acc_q      <= '0;
						mul_a_q    <= one_mod;
						mul_b_q    <= one_mod;
						step_cnt_q <= '0;
						state_q    <= ST_SQUARE;
					end else begin
						acc_q      <= step_val;
						mul_b_q    <= {mul_b_q[OPERAND_WIDTH-2:0], 1'b0};
						step_cnt_q <= step_cnt_q + 1'b1;
					end
				end

				ST_SQUARE: begin
					if (step_last) begin
						acc_q      <= '0;
						step_cnt_q <= '0;
						if (exp_q[OPERAND_WIDTH-1]) begin
							mul_a_q <= base_q;
							mul_b_q <= step_val;
							state_q <= ST_MULT;
						end else if (exp_last) begin
							run_q   <= step_val;
							state_q <= ST_WRITE;
						end else begin
							mul_a_q   <= step_val;
							mul_b_q   <= step_val;
							exp_q     <= {exp_q[OPERAND_WIDTH-2:0], 1'b0};
							exp_cnt_q <= exp_cnt_q + 1'b1;
						end
					end else begin
						acc_q      <= step_val;
						mul_b_q    <= {mul_b_q[OPERAND_WIDTH-2:0], 1'b0};
						step_cnt_q <= step_cnt_q + 1'b1;
					end
				end

				ST_MULT: begin
					if (step_last) begin
						acc_q      <= '0;
						step_cnt_q <= '0;
						if (exp_last) begin
							run_q   <= step_val;
							state_q <= ST_WRITE;
						end else begin
							mul_a_q   <= step_val;
							mul_b_q   <= step_val;
							exp_q     <= {exp_q[OPERAND_WIDTH-2:0], 1'b0};
							exp_cnt_q <= exp_cnt_q + 1'b1;
							state_q   <= ST_SQUARE;
						end
					end else begin
						acc_q      <= step_val;
						mul_b_q    <= {mul_b_q[OPERAND_WIDTH-2:0], 1'b0};
						step_cnt_q <= step_cnt_q + 1'b1;
					end
				end

				ST_WRITE: begin
					if (out_free) begin
						power_result_q <= run_q;
						state_q        <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// No second item is taken while one is still being worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while busy");

	// The multiplicand and the partial sum stay reduced.
	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT)
		|-> (acc_q < modulus_q && mul_a_q < modulus_q))
		else $error("multiplier operand not below modulus");

	// The reduced base is below the modulus whenever it is used.
	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) |-> (base_q < modulus_q))
		else $error("base not reduced");

	// A delivered result is below a nonzero modulus.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && modulus_q != '0) |-> (power_result < modulus_q))
		else $error("result not below modulus");

	// A finished result with a free output register shows up the next cycle.
	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && out_free) |=> (out_valid && !in_stall))
		else $error("finished result not presented");
`endif

endmodule

/* dv/modexp_checker.sv */
// Checker for the modular exponentiation block: it follows the modulus writes, predicts every
// power from the input transfers and compares each output transfer with the oldest prediction.
// Depends on mexp_pkg for the default operand width.
module modexp_checker #(
	parameter int W = mexp_pkg::OPERAND_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write_en,
	input  logic [W-1:0] cfg_write_data,
	input  logic         in_valid,
	input  logic         in_stall,
	input  logic [W-1:0] base_value,
	input  logic [W-1:0] exponent,
	input  logic         out_valid,
	input  logic         out_stall,
	input  logic [W-1:0] power_result,
	output int           failures,
	output int           pending
);

	typedef logic [W-1:0]   word_t;
	typedef logic [2*W-1:0] wide_t;

	word_t modulus_shadow;
	word_t expected_powers[$];

	// Exact product reduction on a double-width product.
	function automatic word_t mul_reduce(input word_t a, input word_t b, input word_t m);
		wide_t prod;
		prod = wide_t'(a) * wide_t'(b);
		return word_t'(prod % wide_t'(m));
	endfunction

	// Left-to-right square and multiply over every exponent bit.
	function automatic word_t predict_power(input word_t b, input word_t e, input word_t m);
		word_t acc;
		word_t red_base;
		if (m == '0) begin
			return '0;
		end
		red_base = b % m;
		acc = word_t'(1) % m;
		for (int i = W - 1; i >= 0; i--) begin
			acc = mul_reduce(acc, acc, m);
			if (e[i]) begin
				acc = mul_reduce(acc, red_base, m);
			end
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			modulus_shadow = '1;
			expected_powers.delete();
			pending = 0;
			failures = 0;
		end else begin
			if (cfg_write_en) begin
				modulus_shadow = cfg_write_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_powers.size() == 0) begin
					$display("%0t: power_result expected none, actual %h", $time,
						power_result);
					failures++;
				end else begin
					want = expected_powers.pop_front();
					if (power_result !== want) begin
						$display("%0t: power_result expected %h, actual %h", $time,
							want, power_result);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_powers.push_back(predict_power(base_value, exponent,
					modulus_shadow));
			end
			pending = expected_powers.size();
		end
	end

endmodule

/* dv/modular_exponentiation_tb.sv */
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
// Depends on mexp_pkg, the modular_exponentiation block and the modexp_checker module.
module modular_exponentiation_tb;

	localparam int W = mexp_pkg::OPERAND_WIDTH_DEF;

	// A result waits on the whole exponentiation, plus receiver stalls and sender gaps,
	// so the watchdog allows several times the slowest legitimate quiet stretch.
	localparam int WATCHDOG_LIMIT = 12000;
	// Cycles allowed after the last result, roughly one full exponentiation.
	localparam int TAIL_CYCLES = 2200;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 27;

	typedef logic [W-1:0] word_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_write_en = 1'b0;
	word_t cfg_write_data = '0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	word_t base_value = '0;
	word_t exponent = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	word_t power_result;

	int    failures;
	int    pending;

	// When quiet is set, neither side idles, so transfers run as closely as the block allows.
	bit    quiet = 1'b0;
	word_t cur_modulus = '1;
	int    stall_left = 0;
	int    idle_cycles = 0;

	always #5 clk = ~clk;

	modular_exponentiation #(
		.OPERAND_WIDTH(W)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent       (exponent),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_result   (power_result)
	);

	modexp_checker #(
		.W(W)
	) checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent       (exponent),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_result   (power_result),
		.failures       (failures),
		.pending        (pending)
	);

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	// The receiver stalls in runs drawn from the same distribution as the sender's gaps.
	always @(posedge clk) begin
		int g;
		if (quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			g = pick_gap();
			out_stall <= (g > 0);
			stall_left = (g > 0) ? g - 1 : 0;
		end
	end

	// The watchdog restarts on every transfer on either channel and ends a hung run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("modular_exponentiation: mismatch");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes it. Valid is lowered only when
	// a gap follows, so a back-to-back item never sees valid dropped and raised in one step.
	task automatic send_item(input word_t b, input word_t e);
		int gap;
		in_valid <= 1'b1;
		base_value <= b;
		exponent <= e;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted power has come back. The first wait
	// lets the checker record a transfer that happened at the current edge.
	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
	endtask

	// The modulus is only written while the block is idle, after a drain.
	task automatic write_modulus(input word_t value);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_modulus = value;
	endtask

	// Bases: full random, values at and just below the modulus, tiny values and all ones.
	function automatic word_t rand_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return word_t'($urandom);
		end else if (r < 85 && cur_modulus > 3) begin
			return cur_modulus - word_t'($urandom_range(0, 3));
		end else if (r < 95) begin
			return word_t'($urandom_range(0, 3));
		end
		return '1;
	endfunction

	// Exponents: full random, small, single bit, dense in ones and zero.
	function automatic word_t rand_exponent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return word_t'($urandom);
		end else if (r < 75) begin
			return word_t'($urandom_range(0, 255));
		end else if (r < 85) begin
			return word_t'(1) << $urandom_range(0, W - 1);
		end else if (r < 95) begin
			return word_t'($urandom) | word_t'($urandom) | word_t'($urandom);
		end
		return '0;
	endfunction

	initial begin
		word_t phase_moduli[RANDOM_PHASES];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset modulus of all ones. A base of all ones reduces
		// to zero here, and exponent zero must give one.
		send_item('0, '0);
		send_item('0, word_t'(1));
		send_item('1, '0);
		send_item('1, '1);
		send_item(word_t'(1), '1);
		send_item(word_t'(2), word_t'(W - 1));
		send_item(word_t'(2), word_t'(W));
		send_item('1 - word_t'(1), word_t'(2));
		send_item({(W / 2){2'b10}}, {(W / 2){2'b10}});
		send_item({(W / 2){2'b01}}, {(W / 2){2'b01}});
		send_item(word_t'(3), word_t'(1) << (W - 1));
		send_item(word_t'(7), '1 >> 1);
		send_item(word_t'(12345), word_t'(1));
		send_item({1'b1, {(W - 1){1'b0}}}, word_t'(3));
		drain_results();

		// A modulus of one makes every power zero, the zero exponent included.
		write_modulus(word_t'(1));
		send_item('0, '0);
		send_item('1, '0);
		send_item('1, '1);
		drain_results();

		// A small modulus with bases at, above and just below it; those at or above must be reduced first.
		write_modulus(word_t'(13));
		send_item(word_t'(13), '0);
		send_item(word_t'(13), word_t'(5));
		send_item(word_t'(26), word_t'(1));
		send_item(word_t'(14), '1);
		send_item(word_t'(12), word_t'(12));
		drain_results();

		// Random phases: each gets its own modulus, the range extremes among them.
		phase_moduli[0] = '1;
		phase_moduli[1] = '1 - word_t'(4);
		phase_moduli[2] = word_t'(1);
		phase_moduli[3] = word_t'(2);
		phase_moduli[4] = word_t'(97);
		phase_moduli[5] = {1'b1, {(W - 1){1'b0}}};
		phase_moduli[6] = word_t'(65537);
		phase_moduli[7] = word_t'($urandom) | {1'b1, {(W - 1){1'b0}}};
		phase_moduli[8] = word_t'($urandom_range(3, 65535));
		phase_moduli[9] = word_t'($urandom) | word_t'(1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// Every third phase runs with no idling on either side.
			quiet = (p % 3 == 1);
			write_modulus(phase_moduli[p]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_item(rand_base(), rand_exponent());
			end
			// The sender pauses here until every result of the phase has come.
			drain_results();
		end

		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0 && pending == 0) begin
			$display("modular_exponentiation: match");
		end else begin
			$display("modular_exponentiation: mismatch");
		end
		$finish;
	end

endmodule
